// ----- src/sqe_pkg.sv -----
// shared types, constants and ring index helpers for the stack/queue engine
package sqe_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OPC_W  = 3;
  localparam int STAT_W = 3;
  localparam int PADDR_W = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH = 3'd0,
    OP_LIST = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_LIST,
    S_SWAP_B,
    S_SWAP_WA,
    S_SWAP_WB
  } state_e;

  localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   SUM_LIM  = (CNT_W + 1)'(DEPTH);

  // one step toward the bottom, with wrap
  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_MAX) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  // one step toward the top, with wrap
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? PTR_MAX : p - PTR_W'(1);
    return r;
  endfunction

  // pointer plus count, count below depth, so one compare and subtract
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
    if (s >= SUM_LIM) begin
      s = s - SUM_LIM;
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ----- src/sqe_ram.sv -----
// simple dual-port ram, one write and one registered read port
module sqe_ram #(
  parameter int Depth = 64,
  parameter int Width = 32,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/stack_queue_engine_top.sv -----
// top level of the bounded stack/queue engine: control, pointers and config port
//
// usage
//   requests enter on start/opcode_i/push_value_i and are taken when start is
//   high and busy is low. every request gives one or more results on
//   data_value_o/has_value_o/status_o/last_o, each shown for exactly one cycle
//   with result_strobe_o high; the receiver cannot stall, so no backpressure.
//   last_o marks the final result of a request.
//   request timing, set by the single read port of the entry ram
//   (registered read, one write per cycle):
//     push, pop, unused opcodes and every error case: result in the cycle after
//       accept, next request accepted in the very next cycle
//     peek: the top entry is read from ram, then registered as the result
//     swap: two reads then two write-backs
//     list: one entry per cycle, top first
//   queue_mode is written through the apb port (register 0 at byte 0); the user
//   writes it only while the block is idle, the block does not enforce this. reset
//   clears pointers, count, mode and the result strobe; the entry ram is not cleared, only occupied entries are read.
module stack_queue_engine_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [sqe_pkg::OPC_W-1:0]      opcode_i,
  input  logic signed [sqe_pkg::DATA_W-1:0] push_value_i,
  // result channel
  output logic                           result_strobe_o,
  output logic signed [sqe_pkg::DATA_W-1:0] data_value_o,
  output logic                           has_value_o,
  output logic [sqe_pkg::STAT_W-1:0]     status_o,
  output logic                           last_o,
  // apb config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sqe_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  import sqe_pkg::*;

  // control state
  state_e             state_q, state_d;
  logic [PTR_W-1:0]   top_q, top_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               mode_q;
  // list walk
  logic [PTR_W-1:0]   list_ptr_q, list_ptr_d;
  logic [CNT_W-1:0]   list_left_q, list_left_d;
  // swap holds the old top entry while the second is read
  logic [DATA_W-1:0]  hold_q, hold_d;

  // result registers
  logic               res_valid_q, res_valid_d;
  logic [DATA_W-1:0]  res_data_q, res_data_d;
  logic               res_has_q, res_has_d;
  status_e            res_status_q, res_status_d;
  logic               res_last_q, res_last_d;

  // ram port
  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_wdata, ram_rdata;

  logic               accept;
  logic               cfg_wr;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // config port: register 0 is queue_mode, anything else reads zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, mode_q} : '0;

  sqe_ram #(
    .Depth (DEPTH),
    .Width (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_LIST: if (count_q != '0) state_d = S_LIST;
            OP_PEEK: if (count_q != '0) state_d = S_PEEK;
            OP_SWAP: if (count_q >= CNT_W'(2)) state_d = S_SWAP_B;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PEEK:    state_d = S_IDLE;
      S_LIST:    if (list_left_q == CNT_W'(1)) state_d = S_IDLE;
      S_SWAP_B:  state_d = S_SWAP_WA;
      S_SWAP_WA: state_d = S_SWAP_WB;
      S_SWAP_WB: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath, ram access and results
  always_comb begin
    top_d        = top_q;
    count_d      = count_q;
    list_ptr_d   = list_ptr_q;
    list_left_d  = list_left_q;
    hold_d       = hold_q;
    ram_we       = 1'b0;
    ram_waddr    = top_q;
    ram_wdata    = push_value_i;
    ram_re       = 1'b0;
    ram_raddr    = top_q;
    res_valid_d  = 1'b0;
    res_data_d   = '0;
    res_has_d    = 1'b0;
    res_status_d = ST_OK;
    res_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_PUSH: begin
              res_valid_d = 1'b1;
              if (count_q == CNT_FULL) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (!mode_q) begin
                  // stack: new entry above the current top
                  ram_waddr = ring_dec(top_q);
                  top_d     = ring_dec(top_q);
                end else begin
                  // queue: new entry below the current bottom
                  ram_waddr = ring_add(top_q, count_q);
                end
              end
            end
            OP_LIST: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                ram_re      = 1'b1;
                list_ptr_d  = ring_inc(top_q);
                list_left_d = count_q;
              end
            end
            OP_PEEK: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_PEEK_EMPTY;
              end else begin
                ram_re = 1'b1;
              end
            end
            OP_POP: begin
              res_valid_d = 1'b1;
              if (count_q == '0) begin
                res_status_d = ST_POP_EMPTY;
              end else begin
                top_d   = ring_inc(top_q);
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_SWAP: begin
              if (count_q < CNT_W'(2)) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_SWAP_SHORT;
              end else begin
                ram_re = 1'b1;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        res_valid_d = 1'b1;
        res_data_d  = ram_rdata;
        res_has_d   = 1'b1;
      end
      S_LIST: begin
        res_valid_d = 1'b1;
        res_data_d  = ram_rdata;
        res_has_d   = 1'b1;
        res_last_d  = (list_left_q == CNT_W'(1));
        if (list_left_q != CNT_W'(1)) begin
          ram_re      = 1'b1;
          ram_raddr   = list_ptr_q;
          list_ptr_d  = ring_inc(list_ptr_q);
          list_left_d = list_left_q - CNT_W'(1);
        end
      end
      S_SWAP_B: begin
        hold_d    = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = ring_inc(top_q);
      end
      S_SWAP_WA: begin
        ram_we    = 1'b1;
        ram_waddr = top_q;
        ram_wdata = ram_rdata;
      end
      S_SWAP_WB: begin
        ram_we      = 1'b1;
        ram_waddr   = ring_inc(top_q);
        ram_wdata   = hold_q;
        res_valid_d = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      count_q     <= '0;
      mode_q      <= 1'b0;
      list_ptr_q  <= '0;
      list_left_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      count_q     <= count_d;
      list_ptr_q  <= list_ptr_d;
      list_left_q <= list_left_d;
      res_valid_q <= res_valid_d;
      if (cfg_wr) begin
        mode_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q       <= hold_d;
    res_data_q   <= res_data_d;
    res_has_q    <= res_has_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign result_strobe_o = res_valid_q;
  assign data_value_o    = res_data_q;
  assign has_value_o     = res_has_q;
  assign status_o        = res_status_q;
  assign last_o          = res_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count above depth");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_PUSH && count_q == CNT_FULL)
    |=> (result_strobe_o && status_o == ST_FULL && count_q == CNT_FULL))
    else $error("push to full store not refused");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_POP && count_q != '0)
    |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not drop the count");

  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && has_value_o) |-> (status_o == ST_OK))
    else $error("value result with error status");
`endif

endmodule
